[src/fnv1_bucket_hash_top_assert.svh]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash: assertion macros
// Concurrent check wrappers used by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FNV1_BUCKET_HASH_TOP_ASSERT_SVH
`define FNV1_BUCKET_HASH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset
`define FBH_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every clock edge, reset included
`define FBH_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FBH_ASSERT(name, clk, rst, prop, msg)
`define FBH_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[src/fnv1bh_pkg.sv]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash package
// Shared widths, constants and types of the hash front, queue and divider.
// ----------------------------------------------------------------------------
package fnv1bh_pkg;

  localparam int HASH_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int BUCKET_W = 32;

  localparam logic [HASH_W-1:0]   FNV_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [BUCKET_W-1:0] BUCKET_RESET     = 32'd1024;

  // Hash queue between front and divider
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = HASH_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // h * 0x100000001b3 mod 2^64 as shifts and adds: 2^40 + 0x1b3
  function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

[src/fnv1_bucket_hash_top.sv]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash top level
// 64-bit FNV-1 key hash reduced modulo a configured bucket count.
//
//   channel   signals                                    dir   beat
//   in        in_valid/in_ready, data_byte, last_byte,   in    one key byte
//             key_is_empty
//   out       out_valid/out_ready, bucket_slot           out   one bucket index
//   cfg       cfg_we, cfg_wdata                          in    bucket count write
//
// Key bytes are taken one per cycle while the two-entry hash queue has room.
// Each finished key goes through the one-bit-per-cycle divider (load, 64
// steps, output); a zero bucket count skips the steps and gives 0.
// Reset restores the offset basis and a bucket count of 1024.
// A stalled output holds the divider; the front keeps taking bytes until
// the queue fills.
// ----------------------------------------------------------------------------
module fnv1_bucket_hash_top
  import fnv1bh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BUCKET_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_byte,
  input  logic                key_is_empty,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BUCKET_W-1:0] bucket_slot
);

  logic [BUCKET_W-1:0] bucket_count;
  q_status_t           q_stat;
  logic                q_push;
  logic                q_pop;
  logic [HASH_W-1:0]   q_wdata;
  logic [HASH_W-1:0]   q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  fnv1bh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .key_is_empty (key_is_empty),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  fnv1bh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  fnv1bh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket_slot  (bucket_slot)
  );

endmodule

[src/fnv1bh_front.sv]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash front
// Takes key bytes, keeps the running hash and queues each finished key hash.
// ----------------------------------------------------------------------------
module fnv1bh_front
  import fnv1bh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  logic              key_is_empty,
  input  q_status_t         q_stat,
  output logic              q_push,
  output logic [HASH_W-1:0] q_wdata
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [HASH_W-1:0] stepped;
  logic              accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign stepped  = fnv_mul(running_hash) ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};

  always_comb begin
    running_hash_next = running_hash;
    q_push            = 1'b0;
    q_wdata           = stepped;
    if (accept) begin
      if (key_is_empty) begin
        // drop any partial key
        running_hash_next = FNV_OFFSET_BASIS;
        q_push            = 1'b1;
        q_wdata           = FNV_OFFSET_BASIS;
      end else if (last_byte) begin
        running_hash_next = FNV_OFFSET_BASIS;
        q_push            = 1'b1;
      end else begin
        running_hash_next = stepped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_OFFSET_BASIS;
    end else begin
      running_hash <= running_hash_next;
    end
  end

endmodule

[src/fnv1bh_queue.sv]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash queue
// Short FIFO of finished key hashes between the front and the divider.
// ----------------------------------------------------------------------------
module fnv1bh_queue
  import fnv1bh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [HASH_W-1:0] wdata,
  input  logic              pop,
  output logic [HASH_W-1:0] rdata,
  output q_status_t         stat
);

  logic [HASH_W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full      = (count == QCNT_W'(QDEPTH));
  assign stat.not_empty = (count != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign rdata          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/fnv1bh_back.sv]
// ----------------------------------------------------------------------------
// FNV-1 bucket hash back end
// Restoring divider reducing each queued hash modulo the bucket count (0 if zero).
// ----------------------------------------------------------------------------
`include "fnv1_bucket_hash_top_assert.svh"

module fnv1bh_back
  import fnv1bh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [BUCKET_W-1:0] bucket_count,
  input  q_status_t           q_stat,
  input  logic [HASH_W-1:0]   q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BUCKET_W-1:0] bucket_slot
);

  back_state_t         state;
  back_state_t         state_next;
  logic [DCNT_W-1:0]   cnt;
  logic [HASH_W-1:0]   dividend;
  logic [BUCKET_W-1:0] divisor;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W:0]   rem_sh;
  logic [BUCKET_W:0]   rem_diff;
  logic                rem_ge;
  logic                last_step;

  assign rem_sh    = {rem, dividend[HASH_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, divisor});
  assign rem_diff  = rem_sh - {1'b0, divisor};
  assign last_step = (cnt == DCNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          // zero divisor skips the division and gives 0
          state_next = (bucket_count == '0) ? BK_OUT : BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    case (state)
      BK_IDLE: q_pop     = q_stat.not_empty;
      BK_OUT:  out_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign bucket_slot = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == BK_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dividend <= q_rdata;
      divisor  <= bucket_count;
      rem      <= '0;
    end else if (state == BK_DIV) begin
      dividend <= {dividend[HASH_W-2:0], 1'b0};
      rem      <= rem_ge ? rem_diff[BUCKET_W-1:0] : rem_sh[BUCKET_W-1:0];
    end
  end

  `FBH_ASSERT(a_pop_has_data, clk, rst, q_pop |-> q_stat.not_empty, "pop from empty queue")
  `FBH_ASSERT(a_divisor_held, clk, rst, (state == BK_DIV && $past(state) == BK_DIV) |-> $stable(divisor), "divisor changed mid division")
  `FBH_ASSERT(a_rem_in_range, clk, rst, (state == BK_OUT && divisor != '0) |-> (rem < divisor), "remainder not below divisor")
  `FBH_ASSERT(a_div_ends, clk, rst, (state == BK_DIV && last_step) |=> (state == BK_OUT), "division did not finish")

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FNV-1 bucket hash testbench
// Streams key bytes through the hash block and tracks a 64-bit FNV-1 hash
// per key alongside it. Every bucket index coming out is checked in order
// against the hash of its key reduced by the bucket count in force. Runs a
// short directed set, then random keys under several bucket counts and
// changing backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench
  import fnv1bh_pkg::*;
();

  localparam logic [HASH_W-1:0] FNV_PRIME    = 64'h0000_0100_0000_01b3;
  localparam int                DRAIN_CYCLES = 200;
  localparam int                KEY_ITEMS    = 160;

  class bucket_scoreboard;
    logic [HASH_W-1:0]   key_hash;
    logic [BUCKET_W-1:0] bucket_count;
    logic [BUCKET_W-1:0] expected_indexes[$];
    int                  errors;

    function new();
      key_hash     = FNV_OFFSET_BASIS;
      bucket_count = BUCKET_RESET;
      errors       = 0;
    endfunction

    function void set_bucket_count(logic [BUCKET_W-1:0] count);
      bucket_count = count;
    endfunction

    function logic [BUCKET_W-1:0] bucket_of(logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] rem;
      if (bucket_count == '0) return '0;
      rem = h % {{(HASH_W-BUCKET_W){1'b0}}, bucket_count};
      return rem[BUCKET_W-1:0];
    endfunction

    function void note_key_byte(logic [BYTE_W-1:0] b, logic last, logic empty);
      if (empty) begin
        // drop any partial key
        key_hash = FNV_OFFSET_BASIS;
        expected_indexes.push_back(bucket_of(FNV_OFFSET_BASIS));
        return;
      end
      key_hash = (key_hash * FNV_PRIME) ^ {{(HASH_W-BYTE_W){1'b0}}, b};
      if (last) begin
        expected_indexes.push_back(bucket_of(key_hash));
        key_hash = FNV_OFFSET_BASIS;
      end
    endfunction

    function void check_bucket_slot(logic [BUCKET_W-1:0] got);
      logic [BUCKET_W-1:0] want;
      if (expected_indexes.size() == 0) begin
        $display("%0t: unexpected bucket_slot: expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = expected_indexes.pop_front();
      if (got !== want) begin
        $display("%0t: bucket_slot mismatch: expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_indexes.size();
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [BUCKET_W-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte    = '0;
  logic                last_byte    = 1'b0;
  logic                key_is_empty = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [BUCKET_W-1:0] bucket_slot;

  int send_idle_pct = 19;
  int recv_idle_pct = 82;

  bucket_scoreboard sb = new();

  fnv1_bucket_hash_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .key_is_empty (key_is_empty),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket_slot  (bucket_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_key_byte(data_byte, last_byte, key_is_empty);
      if (out_valid && out_ready) sb.check_bucket_slot(bucket_slot);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic last,
                           input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    data_byte    = b;
    last_byte    = last;
    key_is_empty = empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_bucket_count(input logic [BUCKET_W-1:0] count);
    cfg_we    = 1'b1;
    cfg_wdata = count;
    sb.set_bucket_count(count);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed keys; some stray empty keys and some keys cut short.
  task automatic run_keys(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        for (int i = 0; i < len; i++) begin
          send_item(BYTE_W'($urandom_range(255)), i == len - 1 && pick >= 10, 1'b0);
        end
        sent += len;
        // abandon the partial key with an empty key
        if (pick < 10) begin
          send_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [BUCKET_W-1:0] counts[9];
    counts[0] = 32'd1;
    counts[1] = 32'hffff_ffff;
    counts[2] = 32'd0;
    counts[3] = $urandom;
    counts[4] = 32'd7;
    counts[5] = 32'h8000_0000;
    counts[6] = $urandom_range(1000, 1);
    counts[7] = BUCKET_RESET;
    counts[8] = $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed keys at the reset bucket count
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hc3, 1'b1, 1'b1);
    send_item(8'haa, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(8'h7f, 1'b1, 1'b0);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 82;
      end else if (p < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_bucket_count(counts[p]);
      run_keys(KEY_ITEMS);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("fnv1_bucket_hash_top regression: pass");
    end else begin
      $display("fnv1_bucket_hash_top regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fnv1_bucket_hash_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/fnv1bh_pkg.sv
src/fnv1bh_front.sv
src/fnv1bh_queue.sv
src/fnv1bh_back.sv
src/fnv1_bucket_hash_top.sv
test/testbench.sv
